### design/tdsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tdsr_pkg;

  // Display geometry
  localparam int ROW_WIDTH = 16;
  localparam int ROW_COUNT = 2;

  localparam int IDX_W  = $clog2(ROW_WIDTH);
  localparam int ROW_AW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int COL_W  = 6;
  localparam int ROWF_W = 3;
  localparam int TEXT_N  = 16;
  localparam int TEXT_AW = 4;

  localparam logic [7:0] SPACE_CHAR = 8'h20;

  // Operation codes
  localparam logic [1:0] OP_SET_CURSOR = 2'd0;
  localparam logic [1:0] OP_CLEAR      = 2'd1;
  localparam logic [1:0] OP_PRINT      = 2'd2;

  // Display command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_CURSOR = 2'd1;
  localparam logic [1:0] CMD_WRITE  = 2'd2;

  typedef struct packed {
    logic [1:0]        operation;
    logic [COL_W-1:0]  col;
    logic [ROWF_W-1:0] row;
    logic [63:0]       chars_low;
    logic [63:0]       chars_high;
    logic [4:0]        text_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [COL_W-1:0]  out_col;
    logic [ROWF_W-1:0] out_row;
    logic [7:0]        char_code;
    logic              last;
  } out_item_t;

  // Shadow store access: one read/write address per cycle, plus bulk clear
  typedef struct packed {
    logic              clr;
    logic              wr;
    logic [ROW_AW-1:0] row;
    logic [IDX_W-1:0]  idx;
    logic [7:0]        wdata;
  } shd_req_t;

  // Padded row character at position i
  function automatic logic [7:0] line_char(input in_item_t it, input logic [IDX_W-1:0] i);
    logic [TEXT_N-1:0][7:0] text;
    logic [7:0]             ch;
    text = {it.chars_high, it.chars_low};
    if (5'(i) < it.text_length) begin
      ch = text[TEXT_AW'(i)];
    end else begin
      ch = SPACE_CHAR;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

### design/tdsr_shadow.sv
`timescale 1ns / 1ps
`default_nettype none

// Shadow copy of the display rows. Per-entry valid bits give the
// all-spaces state after reset or clear without writing every entry.
module tdsr_shadow import tdsr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire shd_req_t req,
  output logic [7:0]    rdata
);

  logic [ROW_COUNT-1:0][ROW_WIDTH-1:0]      vld_r;
  logic [7:0] data_r [ROW_COUNT][ROW_WIDTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.clr) begin
      vld_r <= '0;
    end else if (req.wr) begin
      vld_r[req.row][req.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr) begin
      data_r[req.row][req.idx] <= req.wdata;
    end
  end

  assign rdata = vld_r[req.row][req.idx] ? data_r[req.row][req.idx] : SPACE_CHAR;

endmodule

`default_nettype wire

### design/text_display_shadow_row_diff.sv
`timescale 1ns / 1ps
`default_nettype none

// Set cursor and clear pass through ST_CMD, then offer their command from the output register.
// A print scans the shadow row one character per cycle through one comparator, then emits
// 1 cursor command plus one write per character from first to last difference (0 results
// if unchanged). A print off column 0 or off the display emits all 16 writes, one per cycle
// while the output is not stalled. The input stalls until the current item is done, so a new
// item is taken only once the previous one is through; output stalls hold it longer. Reset
// (rst_n low, synchronous): cursor 0,0, shadow all spaces, no item pending.
module text_display_shadow_row_diff import tdsr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for an item
    ST_CMD,    // emit cursor or clear command
    ST_SCAN,   // compare padded text against shadow row
    ST_CUR,    // emit cursor command at first difference
    ST_DIFF,   // emit changed span and update shadow
    ST_ALL     // emit full row at current cursor
  } state_t;

  state_t            state_r;
  in_item_t          item_r;
  logic [COL_W-1:0]  cursor_col_r;
  logic [ROWF_W-1:0] cursor_row_r;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  first_r;
  logic [IDX_W-1:0]  last_r;
  logic              found_r;
  logic              out_valid_r;
  out_item_t         out_item_r;

  logic       in_accept;
  logic       out_free;
  logic       out_load;
  logic       row_ok;
  logic       idx_end;
  logic       diff;
  logic [7:0] cur_char;
  logic [7:0] shd_rdata;
  shd_req_t   shd_req;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Output register is free when empty or when its item is taken this cycle
  assign out_free = !out_valid_r || !out_stall;
  // Emitting states load a new item whenever the register is free
  assign out_load = out_free && (state_r == ST_CMD || state_r == ST_CUR ||
                                 state_r == ST_DIFF || state_r == ST_ALL);
  assign row_ok   = (cursor_row_r < ROWF_W'(ROW_COUNT));
  assign idx_end  = (idx_r == IDX_W'(ROW_WIDTH - 1));

  // Shared compare unit: one character of the padded row against the shadow
  assign cur_char = line_char(item_r, idx_r);
  assign diff     = (cur_char != shd_rdata);

  always_comb begin
    shd_req.clr   = in_accept && (in_item.operation == OP_CLEAR);
    shd_req.wr    = (state_r == ST_DIFF) && out_free;
    shd_req.row   = cursor_row_r[ROW_AW-1:0];
    shd_req.idx   = idx_r;
    shd_req.wdata = cur_char;
  end

  tdsr_shadow u_shadow (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (shd_req),
    .rdata (shd_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      idx_r        <= '0;
      first_r      <= '0;
      last_r       <= '0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            item_r  <= in_item;
            idx_r   <= '0;
            found_r <= 1'b0;
            case (in_item.operation)
              OP_SET_CURSOR: begin
                cursor_col_r <= in_item.col;
                cursor_row_r <= in_item.row;
                state_r      <= ST_CMD;
              end
              OP_CLEAR: begin
                cursor_col_r <= '0;
                cursor_row_r <= '0;
                state_r      <= ST_CMD;
              end
              OP_PRINT: begin
                // diff only at column 0 of a row the display has
                state_r <= (cursor_col_r == '0 && row_ok) ? ST_SCAN : ST_ALL;
              end
              default: begin
                state_r <= ST_IDLE;  // unused code: dropped
              end
            endcase
          end
        end
        ST_CMD: begin
          if (out_free) begin
            // cursor regs already hold the new position (0,0 after clear)
            out_item_r  <= '{
              command:   (item_r.operation == OP_SET_CURSOR) ? CMD_CURSOR : CMD_CLEAR,
              out_col:   (item_r.operation == OP_SET_CURSOR) ? cursor_col_r : '0,
              out_row:   (item_r.operation == OP_SET_CURSOR) ? cursor_row_r : '0,
              char_code: '0,
              last:      1'b1};
            state_r     <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (diff) begin
            if (!found_r) begin
              first_r <= idx_r;
            end
            last_r  <= idx_r;
            found_r <= 1'b1;
          end
          if (idx_end) begin
            state_r <= (found_r || diff) ? ST_CUR : ST_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_CUR: begin
          if (out_free) begin
            out_item_r  <= '{
              command:   CMD_CURSOR,
              out_col:   COL_W'(first_r),
              out_row:   cursor_row_r,
              char_code: '0,
              last:      1'b0};
            idx_r       <= first_r;
            state_r     <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          if (out_free) begin
            out_item_r  <= '{
              command:   CMD_WRITE,
              out_col:   '0,
              out_row:   '0,
              char_code: cur_char,
              last:      (idx_r == last_r)};
            if (idx_r == last_r) begin
              cursor_col_r <= COL_W'(ROW_WIDTH);
              state_r      <= ST_IDLE;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        ST_ALL: begin
          if (out_free) begin
            out_item_r  <= '{
              command:   CMD_WRITE,
              out_col:   '0,
              out_row:   '0,
              char_code: cur_char,
              last:      idx_end};
            if (idx_end) begin
              state_r <= ST_IDLE;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // A cursor command at the first difference needs a difference to exist
  a_cur_found: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CUR |-> found_r)
    else $error("cursor step without a recorded difference");

  // Changed span is walked from first to last difference
  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIFF |-> (first_r <= idx_r) && (idx_r <= last_r))
    else $error("span index outside first..last");

  // Scan covers the whole row before leaving
  a_scan_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && !idx_end) |=> state_r == ST_SCAN)
    else $error("scan left before the last column");

  // Finishing a span parks the logical cursor past the row
  a_span_col: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIFF && out_free && idx_r == last_r) |=>
      (cursor_col_r == COL_W'(ROW_WIDTH) && state_r == ST_IDLE))
    else $error("cursor column not set after span");

endmodule

`default_nettype wire
